/* rtl/core/dtcb_pkg.sv */
// Shared types and constants for the decimated trace capture buffer.
// No dependencies; used by the top level and the testbench.
package dtcb_pkg;

    localparam int DEPTH_DEF    = 100;
    localparam int CHANNELS_DEF = 9;
    localparam int NUM_CH       = 9;
    localparam int SAMPLE_W     = 16;
    localparam int ROWNUM_W     = 7;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_DUMP   = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        REG_DECIM_STEP = 2'd0,
        REG_CH_ENABLE  = 2'd1,
        REG_CH_IS_BYTE = 2'd2
    } reg_idx_t;

    // Store one channel value: zero when disabled, sign-extend the low byte
    // for byte channels.
    function automatic logic [SAMPLE_W-1:0] capture(input logic [SAMPLE_W-1:0] v,
                                                    input logic en,
                                                    input logic is_byte);
        logic [SAMPLE_W-1:0] r;
        if (!en)
            r = '0;
        else if (is_byte)
            r = {{(SAMPLE_W-8){v[7]}}, v[7:0]};
        else
            r = v;
        return r;
    endfunction

endpackage

/* rtl/core/dtcb_row_store.sv */
// Trace row memory with one write and one registered read port.
// A fill count marks rows never written, which read back as zero.
// Depends on nothing but its parameters.
module dtcb_row_store #(
    parameter int DEPTH = 100,
    parameter int ROW_W = 144
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ROW_W-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ROW_W-1:0]         rd_data
);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [ROW_W-1:0]  mem [DEPTH];
    logic [ROW_W-1:0]  mem_q_reg;
    logic              rd_live_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Rows are written in address order from zero, so row i holds data once
    // the fill count has passed it.
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (fill_reg != FILL_W'(DEPTH)))
            fill_next = fill_reg + FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (rd_en)
                rd_live_reg <= (FILL_W'(rd_addr) < fill_reg);
        end
    end

    assign rd_data = rd_live_reg ? mem_q_reg : '0;

endmodule

/* rtl/core/decimated_trace_capture_buffer.sv */
// Top level of the decimated trace capture buffer: item decode, pointers,
// decimation counter, APB registers and the result pipeline.
// Depends on dtcb_pkg and dtcb_row_store.
//
//  channel  signals                        direction  beat when
//  item     item_valid/item_ready, func,   in         item_valid & item_ready
//           sample_0..sample_8
//  result   res_valid/res_ready,           out        res_valid & res_ready
//           row_number, done_res, row_0..8
//  config   psel/penable/pwrite/paddr/     in         psel & penable & pwrite
//           pwdata/prdata/pready
//
// One item is taken per cycle while item_ready is high. A read item's result
// reaches res_valid through stage 1, where the memory read registers at the
// beat, and then the output register, which loads when stage 1 moves. Reset
// takes effect at once; there is no clearing pass, a fill count makes unwritten
// rows read as zero. A stalled result holds the output register; items keep
// flowing until the read stage behind it is also full.
module decimated_trace_capture_buffer #(
    parameter int DEPTH    = dtcb_pkg::DEPTH_DEF,
    parameter int CHANNELS = dtcb_pkg::CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [1:0]                     func,
    input  logic signed [15:0]             sample_0,
    input  logic signed [15:0]             sample_1,
    input  logic signed [15:0]             sample_2,
    input  logic signed [15:0]             sample_3,
    input  logic signed [15:0]             sample_4,
    input  logic signed [15:0]             sample_5,
    input  logic signed [15:0]             sample_6,
    input  logic signed [15:0]             sample_7,
    input  logic signed [15:0]             sample_8,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic [6:0]                     row_number,
    output logic                           done_res,
    output logic signed [15:0]             row_0,
    output logic signed [15:0]             row_1,
    output logic signed [15:0]             row_2,
    output logic signed [15:0]             row_3,
    output logic signed [15:0]             row_4,
    output logic signed [15:0]             row_5,
    output logic signed [15:0]             row_6,
    output logic signed [15:0]             row_7,
    output logic signed [15:0]             row_8,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dtcb_pkg::PADDR_W-1:0]   paddr,
    input  logic [dtcb_pkg::PDATA_W-1:0]   pwdata,
    output logic [dtcb_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    localparam int SW     = dtcb_pkg::SAMPLE_W;
    localparam int NCH    = dtcb_pkg::NUM_CH;
    localparam int RN_W   = dtcb_pkg::ROWNUM_W;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int RS_W   = $clog2(DEPTH + 1);
    localparam int NUM_W  = (RS_W > RN_W) ? RS_W : RN_W;
    localparam int ROW_W  = CHANNELS * SW;

    // ---------------- configuration ----------------
    logic [15:0]     decim_step_reg;
    logic [NCH-1:0]  ch_enable_reg;
    logic [NCH-1:0]  ch_is_byte_reg;
    logic            cfg_wr;
    logic [1:0]      cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decim_step_reg <= 16'd1;
            ch_enable_reg  <= '0;
            ch_is_byte_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                dtcb_pkg::REG_DECIM_STEP: decim_step_reg <= pwdata[15:0];
                dtcb_pkg::REG_CH_ENABLE:  ch_enable_reg  <= pwdata[NCH-1:0];
                dtcb_pkg::REG_CH_IS_BYTE: ch_is_byte_reg <= pwdata[NCH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            dtcb_pkg::REG_DECIM_STEP: prdata = {16'd0, decim_step_reg};
            dtcb_pkg::REG_CH_ENABLE:  prdata = {{(dtcb_pkg::PDATA_W-NCH){1'b0}}, ch_enable_reg};
            dtcb_pkg::REG_CH_IS_BYTE: prdata = {{(dtcb_pkg::PDATA_W-NCH){1'b0}}, ch_is_byte_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- item decode ----------------
    logic [PTR_W-1:0] write_ptr_reg, write_ptr_next;
    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [15:0]      tick_reg, tick_next, tick_inc;
    logic             dumping_reg, dumping_next;
    logic [RS_W-1:0]  rows_sent_reg, rows_sent_next;

    logic             accept;
    logic             do_sample, do_dump, do_read;
    logic             wr_en, emit_row, emit_done;
    logic             s1_valid_reg, s1_valid_next, s1_move;
    logic             s1_done_reg;
    logic [RN_W-1:0]  s1_num_reg;
    logic [NUM_W-1:0] num_ext;
    logic             res_valid_reg, res_valid_next;

    assign s1_move    = s1_valid_reg && (!res_valid_reg || res_ready);
    assign item_ready = !s1_valid_reg || s1_move;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        do_sample = 1'b0;
        do_dump   = 1'b0;
        do_read   = 1'b0;
        unique case (func)
            dtcb_pkg::FUNC_SAMPLE: do_sample = accept && !dumping_reg;
            dtcb_pkg::FUNC_DUMP:   do_dump   = accept;
            dtcb_pkg::FUNC_READ:   do_read   = accept && dumping_reg;
            default: ;
        endcase
    end

    assign tick_inc  = tick_reg + 16'd1;
    assign wr_en     = do_sample && (tick_inc == decim_step_reg);
    assign emit_row  = do_read && (rows_sent_reg != RS_W'(DEPTH));
    assign emit_done = do_read && (rows_sent_reg == RS_W'(DEPTH));
    assign num_ext   = NUM_W'(rows_sent_reg) + NUM_W'(1);

    always_comb
    begin
        write_ptr_next = write_ptr_reg;
        read_ptr_next  = read_ptr_reg;
        tick_next      = tick_reg;
        dumping_next   = dumping_reg;
        rows_sent_next = rows_sent_reg;

        if (do_sample)
            tick_next = wr_en ? 16'd0 : tick_inc;
        if (wr_en)
            write_ptr_next = (write_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                           : write_ptr_reg + PTR_W'(1);
        if (do_dump)
        begin
            dumping_next  = 1'b1;
            read_ptr_next = write_ptr_reg;
        end
        if (emit_row)
        begin
            rows_sent_next = rows_sent_reg + RS_W'(1);
            read_ptr_next  = (read_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                           : read_ptr_reg + PTR_W'(1);
        end
        if (emit_done)
        begin
            dumping_next   = 1'b0;
            rows_sent_next = '0;
        end
        // decim_step writes clear the counter; the user runs no item alongside, the block does not enforce it
        if (cfg_wr && (cfg_idx == dtcb_pkg::REG_DECIM_STEP))
            tick_next = 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_reg <= '0;
            read_ptr_reg  <= '0;
            tick_reg      <= '0;
            dumping_reg   <= 1'b0;
            rows_sent_reg <= '0;
        end
        else
        begin
            write_ptr_reg <= write_ptr_next;
            read_ptr_reg  <= read_ptr_next;
            tick_reg      <= tick_next;
            dumping_reg   <= dumping_next;
            rows_sent_reg <= rows_sent_next;
        end
    end

    // ---------------- row capture and memory ----------------
    logic [SW-1:0]    smp [NCH];
    logic [ROW_W-1:0] wr_data;
    logic [ROW_W-1:0] rd_data;

    assign smp[0] = sample_0;
    assign smp[1] = sample_1;
    assign smp[2] = sample_2;
    assign smp[3] = sample_3;
    assign smp[4] = sample_4;
    assign smp[5] = sample_5;
    assign smp[6] = sample_6;
    assign smp[7] = sample_7;
    assign smp[8] = sample_8;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_cap
        assign wr_data[c*SW +: SW] = dtcb_pkg::capture(smp[c], ch_enable_reg[c],
                                                       ch_is_byte_reg[c]);
    end

    dtcb_row_store #(
        .DEPTH (DEPTH),
        .ROW_W (ROW_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (write_ptr_reg),
        .wr_data (wr_data),
        .rd_en   (emit_row),
        .rd_addr (read_ptr_reg),
        .rd_data (rd_data)
    );

    // ---------------- result pipeline ----------------
    // Stage 1 waits on the memory read; the output register follows.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (do_read)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (s1_move)
            res_valid_next = 1'b1;
        else if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    logic [RN_W-1:0] res_num_reg;
    logic            res_done_reg;
    logic [SW-1:0]   res_row_reg [NCH];

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            s1_done_reg <= emit_done;
            s1_num_reg  <= emit_done ? '0 : num_ext[RN_W-1:0];
        end
        if (s1_move)
        begin
            res_num_reg  <= s1_num_reg;
            res_done_reg <= s1_done_reg;
        end
    end

    for (genvar c = 0; c < NCH; c++)
    begin : g_res
        if (c < CHANNELS)
        begin : g_live
            always_ff @(posedge clk)
            begin
                if (s1_move)
                    res_row_reg[c] <= s1_done_reg ? '0 : rd_data[c*SW +: SW];
            end
        end
        else
        begin : g_zero
            assign res_row_reg[c] = '0;
        end
    end

    assign res_valid  = res_valid_reg;
    assign row_number = res_num_reg;
    assign done_res   = res_done_reg;
    assign row_0      = res_row_reg[0];
    assign row_1      = res_row_reg[1];
    assign row_2      = res_row_reg[2];
    assign row_3      = res_row_reg[3];
    assign row_4      = res_row_reg[4];
    assign row_5      = res_row_reg[5];
    assign row_6      = res_row_reg[6];
    assign row_7      = res_row_reg[7];
    assign row_8      = res_row_reg[8];

endmodule

/* rtl/core/dtcb_checker.sv */
// Port-level checks for the decimated trace capture buffer, and the bind
// that attaches them to the top level. Depends on the top level's ports.
module dtcb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [6:0]        row_number,
    input logic              done_res,
    input logic signed [15:0] row_0,
    input logic signed [15:0] row_4,
    input logic signed [15:0] row_8,
    input logic              pready
);
    // A stalled result beat holds its row number, end flag and row_0.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(row_number)
            && $stable(done_res) && $stable(row_0))
        else $error("result beat changed while stalled");

    // The end marker carries row number zero and blank rows 0, 4 and 8.
    a_done_blank: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> row_number == 7'd0 && row_0 == 16'sd0
            && row_4 == 16'sd0 && row_8 == 16'sd0)
        else $error("end marker carries data");

    // A data row is numbered from one.
    a_row_numbered: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !done_res |-> row_number != 7'd0)
        else $error("data row without row number");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind decimated_trace_capture_buffer dtcb_checker u_dtcb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .row_number (row_number),
    .done_res   (done_res),
    .row_0      (row_0),
    .row_4      (row_4),
    .row_8      (row_8),
    .pready     (pready)
);

/* test/tb_decimated_trace_capture_buffer.sv */
// Self-checking testbench for decimated_trace_capture_buffer: directed and random
// items with a row predictor, result checking and APB register writes between phases.
// Depends on dtcb_pkg and the decimated_trace_capture_buffer RTL.
module tb_decimated_trace_capture_buffer;

    localparam int         DEPTH       = dtcb_pkg::DEPTH_DEF;
    localparam int         NCH         = dtcb_pkg::NUM_CH;
    localparam int         SW          = dtcb_pkg::SAMPLE_W;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         MAX_REPORTS = 200;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                         op;
        logic [NCH-1:0][SW-1:0]             smp;
    } trace_item_t;

    typedef struct packed {
        logic [dtcb_pkg::ROWNUM_W-1:0]      num;
        logic                               done;
        logic [NCH-1:0][SW-1:0]             val;
    } trace_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    logic [1:0]             func;
    logic signed [15:0]     sample_0, sample_1, sample_2, sample_3, sample_4;
    logic signed [15:0]     sample_5, sample_6, sample_7, sample_8;
    logic                   res_valid;
    logic                   res_ready;
    logic [6:0]             row_number;
    logic                   done_res;
    logic signed [15:0]     row_0, row_1, row_2, row_3, row_4;
    logic signed [15:0]     row_5, row_6, row_7, row_8;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [dtcb_pkg::PADDR_W-1:0] paddr;
    logic [dtcb_pkg::PDATA_W-1:0] pwdata;
    logic [dtcb_pkg::PDATA_W-1:0] prdata;
    logic                   pready;

    // predictor state and register copies
    logic [NCH-1:0][SW-1:0] trace_mem [DEPTH];
    int                     m_write_ptr;
    int                     m_read_ptr;
    int                     m_rows_sent;
    logic [15:0]            m_tick;
    logic                   m_dumping;
    logic [15:0]            m_decim;
    logic [8:0]             m_enable;
    logic [8:0]             m_is_byte;

    trace_item_t            item_q[$];
    trace_row_t             rows_expected[$];
    int                     items_queued;
    int                     items_issued;
    int                     items_accepted;
    int                     results_seen;
    int                     results_paced;
    int                     gap_left;
    int                     stall_left;
    int                     tx_gap_max;
    int                     rx_stall_max;
    int                     err_cnt;
    int                     cycle_cnt;

    decimated_trace_capture_buffer #(
        .DEPTH      (DEPTH),
        .CHANNELS   (dtcb_pkg::CHANNELS_DEF)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .func       (func),
        .sample_0   (sample_0),
        .sample_1   (sample_1),
        .sample_2   (sample_2),
        .sample_3   (sample_3),
        .sample_4   (sample_4),
        .sample_5   (sample_5),
        .sample_6   (sample_6),
        .sample_7   (sample_7),
        .sample_8   (sample_8),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .row_number (row_number),
        .done_res   (done_res),
        .row_0      (row_0),
        .row_1      (row_1),
        .row_2      (row_2),
        .row_3      (row_3),
        .row_4      (row_4),
        .row_5      (row_5),
        .row_6      (row_6),
        .row_7      (row_7),
        .row_8      (row_8),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    // Apply one accepted item to the predictor; queue the row a read produces.
    function automatic void advance_trace(trace_item_t it);
        trace_row_t r;
        logic [SW-1:0] s;
        case (it.op)
            dtcb_pkg::FUNC_SAMPLE:
            begin
                if (!m_dumping)
                begin
                    m_tick = m_tick + 16'd1;
                    if (m_tick == m_decim)
                    begin
                        m_tick = '0;
                        if (m_write_ptr >= DEPTH)
                            m_write_ptr = 0;
                        for (int c = 0; c < NCH; c++)
                        begin
                            s = it.smp[c];
                            if (!m_enable[c])
                                trace_mem[m_write_ptr][c] = '0;
                            else if (m_is_byte[c])
                                trace_mem[m_write_ptr][c] = {{8{s[7]}}, s[7:0]};
                            else
                                trace_mem[m_write_ptr][c] = s;
                        end
                        m_write_ptr++;
                        if (m_write_ptr >= DEPTH)
                            m_write_ptr = 0;
                    end
                end
            end
            dtcb_pkg::FUNC_DUMP:
            begin
                // rows already sent stay counted on a restart
                m_dumping  = 1'b1;
                m_read_ptr = m_write_ptr;
            end
            dtcb_pkg::FUNC_READ:
            begin
                if (m_dumping)
                begin
                    if (m_rows_sent < DEPTH)
                    begin
                        m_rows_sent++;
                        if (m_read_ptr >= DEPTH)
                            m_read_ptr = 0;
                        r.num  = dtcb_pkg::ROWNUM_W'(m_rows_sent);
                        r.done = 1'b0;
                        r.val  = trace_mem[m_read_ptr];
                        m_read_ptr++;
                    end
                    else
                    begin
                        r.num       = '0;
                        r.done      = 1'b1;
                        r.val       = '0;
                        m_dumping   = 1'b0;
                        m_rows_sent = 0;
                    end
                    rows_expected.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0080;
            3: return 16'h007F;
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic void push_op(logic [1:0] op);
        trace_item_t it;
        it.op = op;
        for (int c = 0; c < NCH; c++)
            it.smp[c] = pick_sample();
        item_q.push_back(it);
        items_queued++;
    endfunction

    // Sample tick with the same value on every channel.
    function automatic void push_level(logic [SW-1:0] v);
        trace_item_t it;
        it.op = dtcb_pkg::FUNC_SAMPLE;
        for (int c = 0; c < NCH; c++)
            it.smp[c] = v;
        item_q.push_back(it);
        items_queued++;
    endfunction

    task automatic write_reg(dtcb_pkg::reg_idx_t idx, logic [dtcb_pkg::PDATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            dtcb_pkg::REG_DECIM_STEP:
            begin
                m_decim = val[15:0];
                m_tick  = '0;
            end
            dtcb_pkg::REG_CH_ENABLE:  m_enable  = val[8:0];
            dtcb_pkg::REG_CH_IS_BYTE: m_is_byte = val[8:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold the sender until every beat is taken and every row has come back.
    task automatic wait_idle();
        while (item_q.size() != 0 || items_issued != items_accepted ||
               rows_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : item_driver
        trace_item_t cur;
        if (!rst_n)
            item_valid <= 1'b0;
        else if (items_issued == items_accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (item_q.size() != 0)
            begin
                cur = item_q.pop_front();
                func       <= cur.op;
                sample_0   <= cur.smp[0];
                sample_1   <= cur.smp[1];
                sample_2   <= cur.smp[2];
                sample_3   <= cur.smp[3];
                sample_4   <= cur.smp[4];
                sample_5   <= cur.smp[5];
                sample_6   <= cur.smp[6];
                sample_7   <= cur.smp[7];
                sample_8   <= cur.smp[8];
                item_valid <= 1'b1;
                items_issued++;
                gap_left = $urandom_range(0, tx_gap_max);
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : item_accept
        trace_item_t it;
        if (rst_n && item_valid && item_ready)
        begin
            it.op  = func;
            it.smp = {sample_8, sample_7, sample_6, sample_5, sample_4,
                      sample_3, sample_2, sample_1, sample_0};
            items_accepted++;
            advance_trace(it);
        end
    end

    always @(negedge clk)
    begin : result_pacer
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            // draw a new stall after each result beat
            if (results_seen != results_paced)
            begin
                results_paced = results_seen;
                stall_left    = $urandom_range(0, rx_stall_max);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : row_check
        trace_row_t got;
        trace_row_t want;
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            got.num  = row_number;
            got.done = done_res;
            got.val  = {row_8, row_7, row_6, row_5, row_4, row_3, row_2, row_1, row_0};
            if (rows_expected.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected row: row_number %0d done %0b",
                             $time, got.num, got.done);
            end
            else
            begin
                want = rows_expected.pop_front();
                if (got.num !== want.num)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: row_number expected %0d, got %0d",
                                 $time, want.num, got.num);
                end
                if (got.done !== want.done)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: done_res expected %0b, got %0b",
                                 $time, want.done, got.done);
                end
                for (int c = 0; c < NCH; c++)
                begin
                    if (got.val[c] !== want.val[c])
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: row_%0d expected %h, got %h",
                                     $time, c, want.val[c], got.val[c]);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_decimated_trace_capture_buffer: errors");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        int k;
        int kind;
        logic [8:0] mask;

        clk        = 1'b0;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        res_ready  = 1'b0;
        func       = dtcb_pkg::FUNC_SAMPLE;
        sample_0   = '0;
        sample_1   = '0;
        sample_2   = '0;
        sample_3   = '0;
        sample_4   = '0;
        sample_5   = '0;
        sample_6   = '0;
        sample_7   = '0;
        sample_8   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        foreach (trace_mem[i])
            trace_mem[i] = '0;
        m_write_ptr    = 0;
        m_read_ptr     = 0;
        m_rows_sent    = 0;
        m_tick         = '0;
        m_dumping      = 1'b0;
        m_decim        = 16'd1;
        m_enable       = '0;
        m_is_byte      = '0;
        items_queued   = 0;
        items_issued   = 0;
        items_accepted = 0;
        results_seen   = 0;
        results_paced  = 0;
        gap_left       = 0;
        stall_left     = 0;
        tx_gap_max     = 9;
        rx_stall_max   = 9;
        err_cnt        = 0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: all channels disabled, so this row is zeros.
        // Also a read outside a dump and the unused selector.
        push_level(16'h1234);
        push_op(dtcb_pkg::FUNC_READ);
        push_op(FUNC_UNUSED);
        wait_idle();

        write_reg(dtcb_pkg::REG_CH_ENABLE, 32'h1FF);
        write_reg(dtcb_pkg::REG_CH_IS_BYTE, 32'h0AA);
        write_reg(dtcb_pkg::REG_DECIM_STEP, 32'd1);
        push_level(16'h7FFF);
        push_level(16'h8000);
        push_level(16'h0000);
        push_level(16'hFFFF);
        push_level(16'h0080);
        push_level(16'h007F);
        push_op(dtcb_pkg::FUNC_DUMP);
        repeat (3) push_op(dtcb_pkg::FUNC_READ);
        // a tick while dumping is dropped; a second dump restarts the pointer
        push_op(dtcb_pkg::FUNC_SAMPLE);
        push_op(dtcb_pkg::FUNC_DUMP);
        repeat (2) push_op(dtcb_pkg::FUNC_READ);
        push_op(FUNC_UNUSED);
        wait_idle();

        while (items_queued < 1200)
        begin
            tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 9;
            rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
            if ($urandom_range(0, 1))
                write_reg(dtcb_pkg::REG_DECIM_STEP, $urandom_range(1, 4));
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 3))
                    0: mask = 9'h000;
                    1: mask = 9'h1FF;
                    default: mask = 9'($urandom);
                endcase
                write_reg(dtcb_pkg::REG_CH_ENABLE, {23'd0, mask});
            end
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 3))
                    0: mask = 9'h000;
                    1: mask = 9'h1FF;
                    default: mask = 9'($urandom);
                endcase
                write_reg(dtcb_pkg::REG_CH_IS_BYTE, {23'd0, mask});
            end

            // finish any dump left open so the ticks below get recorded
            if (m_dumping)
                repeat (DEPTH + 1 - m_rows_sent) push_op(dtcb_pkg::FUNC_READ);

            n = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 260) : $urandom_range(1, 60);
            repeat (n)
            begin
                case ($urandom_range(0, 19))
                    0: push_op(FUNC_UNUSED);
                    1: push_op(dtcb_pkg::FUNC_READ);
                    default: push_op(dtcb_pkg::FUNC_SAMPLE);
                endcase
            end
            push_op(dtcb_pkg::FUNC_DUMP);
            if ($urandom_range(0, 3) == 0)
                wait_idle();

            kind = $urandom_range(0, 5);
            if (kind == 0)
            begin
                k = $urandom_range(0, DEPTH);
                repeat (k) push_op(dtcb_pkg::FUNC_READ);
                push_op(dtcb_pkg::FUNC_DUMP);
                repeat (DEPTH + 1 - k) push_op(dtcb_pkg::FUNC_READ);
            end
            else if (kind == 1)
            begin
                k = 0;
                while (k < DEPTH + 1)
                begin
                    if ($urandom_range(0, 7) == 0)
                        push_op(dtcb_pkg::FUNC_SAMPLE);
                    else
                    begin
                        push_op(dtcb_pkg::FUNC_READ);
                        k++;
                    end
                end
            end
            else
                repeat (DEPTH + 1) push_op(dtcb_pkg::FUNC_READ);
            repeat ($urandom_range(0, 2)) push_op(dtcb_pkg::FUNC_READ);
            wait_idle();
        end

        // Widest step, then step zero: neither stores a row within a short
        // run of ticks, so the dump shows the rows from before.
        tx_gap_max   = 0;
        rx_stall_max = 9;
        write_reg(dtcb_pkg::REG_DECIM_STEP, 32'd65535);
        write_reg(dtcb_pkg::REG_CH_ENABLE, 32'h1FF);
        write_reg(dtcb_pkg::REG_CH_IS_BYTE, 32'h000);
        repeat (120) push_op(dtcb_pkg::FUNC_SAMPLE);
        wait_idle();

        write_reg(dtcb_pkg::REG_DECIM_STEP, 32'd0);
        write_reg(dtcb_pkg::REG_CH_IS_BYTE, 32'h1FF);
        repeat (120) push_op(dtcb_pkg::FUNC_SAMPLE);
        push_op(dtcb_pkg::FUNC_DUMP);
        repeat (DEPTH + 1) push_op(dtcb_pkg::FUNC_READ);
        wait_idle();

        repeat (10) @(posedge clk);
        if (err_cnt == 0 && rows_expected.size() == 0)
            $display("tb_decimated_trace_capture_buffer: clean");
        else
            $display("tb_decimated_trace_capture_buffer: errors");
        $finish;
    end

endmodule
